FILE: design/bss_pkg.sv
// Shared constants and types for the Bezier segment splitter.
package bss_pkg;

   localparam int MODE_WIDTH = 2;
   localparam logic [MODE_WIDTH-1:0] MODE_QUAD  = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_CUBIC = 2'd3;

   localparam int LERP_STAGES = 3;
   localparam int LEVELS      = 3;
   localparam int PIPE_STAGES = LERP_STAGES * LEVELS;

   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } lerp_ctrl_type;

endpackage

FILE: design/bss_ifs.sv
// Valid/ready channel interfaces for segment requests and half-segment responses.
interface bss_req_if import bss_pkg::*; #(
   parameter int COORD_WIDTH     = 32,
   parameter int PARAM_FRAC_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic [MODE_WIDTH-1:0]         mode;
   logic signed [COORD_WIDTH-1:0] p1_x;
   logic signed [COORD_WIDTH-1:0] p1_y;
   logic signed [COORD_WIDTH-1:0] c1_x;
   logic signed [COORD_WIDTH-1:0] c1_y;
   logic signed [COORD_WIDTH-1:0] c2_x;
   logic signed [COORD_WIDTH-1:0] c2_y;
   logic signed [COORD_WIDTH-1:0] p2_x;
   logic signed [COORD_WIDTH-1:0] p2_y;
   logic [PARAM_FRAC_BITS:0]      split_at;
   logic [PARAM_FRAC_BITS:0]      param_start;
   logic [PARAM_FRAC_BITS:0]      param_end;

   modport source (
      output valid, mode, p1_x, p1_y, c1_x, c1_y, c2_x, c2_y, p2_x, p2_y,
             split_at, param_start, param_end,
      input  ready
   );
   modport sink (
      input  valid, mode, p1_x, p1_y, c1_x, c1_y, c2_x, c2_y, p2_x, p2_y,
             split_at, param_start, param_end,
      output ready
   );
endinterface

interface bss_rsp_if #(
   parameter int COORD_WIDTH     = 32,
   parameter int PARAM_FRAC_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] half_p1_x;
   logic signed [COORD_WIDTH-1:0] half_p1_y;
   logic signed [COORD_WIDTH-1:0] half_c1_x;
   logic signed [COORD_WIDTH-1:0] half_c1_y;
   logic signed [COORD_WIDTH-1:0] half_c2_x;
   logic signed [COORD_WIDTH-1:0] half_c2_y;
   logic signed [COORD_WIDTH-1:0] half_p2_x;
   logic signed [COORD_WIDTH-1:0] half_p2_y;
   logic [PARAM_FRAC_BITS:0]      half_param_start;
   logic [PARAM_FRAC_BITS:0]      half_param_end;
   logic                          is_last;

   modport source (
      output valid, half_p1_x, half_p1_y, half_c1_x, half_c1_y, half_c2_x, half_c2_y,
             half_p2_x, half_p2_y, half_param_start, half_param_end, is_last,
      input  ready
   );
   modport sink (
      input  valid, half_p1_x, half_p1_y, half_c1_x, half_c1_y, half_c2_x, half_c2_y,
             half_p2_x, half_p2_y, half_param_start, half_param_end, is_last,
      output ready
   );
endinterface

FILE: design/bezier_segment_split.sv
// Top level: de Casteljau split of a linear, quadratic or cubic segment into two halves.
// Pipeline: three lerp levels of 3 stages each feed the output register, which presents the
// first half; the second half follows in the cycle after the first is taken.
// Throughput: bounded by the two response transactions per segment on the single response
// channel; the lerp pipeline itself accepts one segment per cycle unless back-pressure stalls it.
// Reset: synchronous; clears the stage valid bits and the output register's valid and beat flags, no data state.
module bezier_segment_split import bss_pkg::*; #(
   parameter int COORD_WIDTH     = 32,
   parameter int PARAM_FRAC_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   bss_req_if.sink   req_if,
   bss_rsp_if.source rsp_if
);

   localparam int PW         = PARAM_FRAC_BITS + 1;
   localparam int HEAD_WIDTH = MODE_WIDTH + 4 * COORD_WIDTH + 2 * PW;
   localparam int L1_WIDTH   = 6 * COORD_WIDTH + PW;
   localparam int L2_WIDTH   = 4 * COORD_WIDTH;
   localparam int HALF_WIDTH = 8 * COORD_WIDTH + 2 * PW;

   logic [PIPE_STAGES-1:0] vld_ff, vld_in;
   logic [PIPE_STAGES-1:0] en;
   logic                   emit_take;
   lerp_ctrl_type          lvl_ctrl [LEVELS];

   logic signed [COORD_WIDTH-1:0] in_p1 [2];
   logic signed [COORD_WIDTH-1:0] in_c1 [2];
   logic signed [COORD_WIDTH-1:0] in_c2 [2];
   logic signed [COORD_WIDTH-1:0] in_p2 [2];
   logic                          is_curve, is_cubic;

   logic signed [COORD_WIDTH-1:0] l1a [2];
   logic signed [COORD_WIDTH-1:0] l1b [2];
   logic signed [COORD_WIDTH-1:0] l1c [2];
   logic signed [COORD_WIDTH-1:0] l2f [2];
   logic signed [COORD_WIDTH-1:0] l2s [2];
   logic signed [COORD_WIDTH-1:0] mid [2];
   logic signed [PW:0]            pm_y;
   logic [PW-1:0]                 pm;

   logic [PW-1:0]       t_l2, t_l3;
   logic [HEAD_WIDTH-1:0] head_in, head_out;
   logic [L1_WIDTH-1:0]   l1_in, l1_out;
   logic [L2_WIDTH-1:0]   l2_in, l2_out;

   logic [MODE_WIDTH-1:0]         hd_mode;
   logic signed [COORD_WIDTH-1:0] hd_p1 [2];
   logic signed [COORD_WIDTH-1:0] hd_p2 [2];
   logic [PW-1:0]                 hd_ps, hd_pe, hd_pm;
   logic signed [COORD_WIDTH-1:0] d_l1a [2];
   logic signed [COORD_WIDTH-1:0] d_l1b [2];
   logic signed [COORD_WIDTH-1:0] d_l1c [2];
   logic signed [COORD_WIDTH-1:0] d_l2f [2];
   logic signed [COORD_WIDTH-1:0] d_l2s [2];

   logic signed [COORD_WIDTH-1:0] fa_c1 [2];
   logic signed [COORD_WIDTH-1:0] fa_c2 [2];
   logic signed [COORD_WIDTH-1:0] fa_mid [2];
   logic signed [COORD_WIDTH-1:0] sb_c1 [2];
   logic signed [COORD_WIDTH-1:0] sb_c2 [2];
   logic [HALF_WIDTH-1:0]         first_half, second_half;

   always_comb begin
      en[PIPE_STAGES-1] = !vld_ff[PIPE_STAGES-1] || emit_take;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = en[0] ? req_if.valid : vld_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_if.ready = en[0];

   for (genvar l = 0; l < LEVELS; l++) begin : g_ctrl
      assign lvl_ctrl[l] = '{s1_en: en[LERP_STAGES*l],
                             s2_en: en[LERP_STAGES*l+1],
                             s3_en: en[LERP_STAGES*l+2]};
   end

   assign in_p1[0] = req_if.p1_x;
   assign in_p1[1] = req_if.p1_y;
   assign in_c1[0] = req_if.c1_x;
   assign in_c1[1] = req_if.c1_y;
   assign in_c2[0] = req_if.c2_x;
   assign in_c2[1] = req_if.c2_y;
   assign in_p2[0] = req_if.p2_x;
   assign in_p2[1] = req_if.p2_y;

   assign is_cubic = (req_if.mode == MODE_CUBIC);
   assign is_curve = req_if.mode inside {MODE_QUAD, MODE_CUBIC};

   for (genvar k = 0; k < 2; k++) begin : g_axis
      bss_lerp #(.VAL_WIDTH(COORD_WIDTH), .FRAC_BITS(PARAM_FRAC_BITS)) u_l1a (
         .clock (clock),
         .ctrl  (lvl_ctrl[0]),
         .a     (in_p1[k]),
         .b     (is_curve ? in_c1[k] : in_p2[k]),
         .t     (req_if.split_at),
         .y     (l1a[k])
      );
      bss_lerp #(.VAL_WIDTH(COORD_WIDTH), .FRAC_BITS(PARAM_FRAC_BITS)) u_l1b (
         .clock (clock),
         .ctrl  (lvl_ctrl[0]),
         .a     (in_c1[k]),
         .b     (is_cubic ? in_c2[k] : in_p2[k]),
         .t     (req_if.split_at),
         .y     (l1b[k])
      );
      bss_lerp #(.VAL_WIDTH(COORD_WIDTH), .FRAC_BITS(PARAM_FRAC_BITS)) u_l1c (
         .clock (clock),
         .ctrl  (lvl_ctrl[0]),
         .a     (in_c2[k]),
         .b     (in_p2[k]),
         .t     (req_if.split_at),
         .y     (l1c[k])
      );
      bss_lerp #(.VAL_WIDTH(COORD_WIDTH), .FRAC_BITS(PARAM_FRAC_BITS)) u_l2f (
         .clock (clock),
         .ctrl  (lvl_ctrl[1]),
         .a     (l1a[k]),
         .b     (l1b[k]),
         .t     (t_l2),
         .y     (l2f[k])
      );
      bss_lerp #(.VAL_WIDTH(COORD_WIDTH), .FRAC_BITS(PARAM_FRAC_BITS)) u_l2s (
         .clock (clock),
         .ctrl  (lvl_ctrl[1]),
         .a     (l1b[k]),
         .b     (l1c[k]),
         .t     (t_l2),
         .y     (l2s[k])
      );
      bss_lerp #(.VAL_WIDTH(COORD_WIDTH), .FRAC_BITS(PARAM_FRAC_BITS)) u_l3 (
         .clock (clock),
         .ctrl  (lvl_ctrl[2]),
         .a     (l2f[k]),
         .b     (l2s[k]),
         .t     (t_l3),
         .y     (mid[k])
      );
   end

   bss_lerp #(.VAL_WIDTH(PW + 1), .FRAC_BITS(PARAM_FRAC_BITS)) u_param (
      .clock (clock),
      .ctrl  (lvl_ctrl[0]),
      .a     ($signed({1'b0, req_if.param_start})),
      .b     ($signed({1'b0, req_if.param_end})),
      .t     (req_if.split_at),
      .y     (pm_y)
   );

   assign pm = pm_y[PW] ? '0 : pm_y[PW-1:0];

   bss_delay #(.WIDTH(PW), .DEPTH(LERP_STAGES)) u_t_l2 (
      .clock (clock),
      .en    (en[LERP_STAGES-1:0]),
      .din   (req_if.split_at),
      .dout  (t_l2)
   );

   bss_delay #(.WIDTH(PW), .DEPTH(LERP_STAGES)) u_t_l3 (
      .clock (clock),
      .en    (en[2*LERP_STAGES-1:LERP_STAGES]),
      .din   (t_l2),
      .dout  (t_l3)
   );

   assign head_in = {req_if.mode, req_if.p1_x, req_if.p1_y, req_if.p2_x, req_if.p2_y,
                     req_if.param_start, req_if.param_end};

   bss_delay #(.WIDTH(HEAD_WIDTH), .DEPTH(PIPE_STAGES)) u_head (
      .clock (clock),
      .en    (en),
      .din   (head_in),
      .dout  (head_out)
   );

   assign l1_in = {l1a[0], l1a[1], l1b[0], l1b[1], l1c[0], l1c[1], pm};

   bss_delay #(.WIDTH(L1_WIDTH), .DEPTH(PIPE_STAGES - LERP_STAGES)) u_l1_line (
      .clock (clock),
      .en    (en[PIPE_STAGES-1:LERP_STAGES]),
      .din   (l1_in),
      .dout  (l1_out)
   );

   assign l2_in = {l2f[0], l2f[1], l2s[0], l2s[1]};

   bss_delay #(.WIDTH(L2_WIDTH), .DEPTH(PIPE_STAGES - 2 * LERP_STAGES)) u_l2_line (
      .clock (clock),
      .en    (en[PIPE_STAGES-1:2*LERP_STAGES]),
      .din   (l2_in),
      .dout  (l2_out)
   );

   assign {hd_mode, hd_p1[0], hd_p1[1], hd_p2[0], hd_p2[1], hd_ps, hd_pe} = head_out;
   assign {d_l1a[0], d_l1a[1], d_l1b[0], d_l1b[1], d_l1c[0], d_l1c[1], hd_pm} = l1_out;
   assign {d_l2f[0], d_l2f[1], d_l2s[0], d_l2s[1]} = l2_out;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         case (hd_mode)
            MODE_CUBIC: begin
               fa_c1[k]  = d_l1a[k];
               fa_c2[k]  = d_l2f[k];
               fa_mid[k] = mid[k];
               sb_c1[k]  = d_l2s[k];
               sb_c2[k]  = d_l1c[k];
            end
            MODE_QUAD: begin
               fa_c1[k]  = d_l1a[k];
               fa_c2[k]  = d_l1a[k];
               fa_mid[k] = d_l2f[k];
               sb_c1[k]  = d_l1b[k];
               sb_c2[k]  = d_l1b[k];
            end
            default: begin
               fa_c1[k]  = '0;
               fa_c2[k]  = '0;
               fa_mid[k] = d_l1a[k];
               sb_c1[k]  = '0;
               sb_c2[k]  = '0;
            end
         endcase
      end
   end

   assign first_half  = {hd_p1[0], hd_p1[1], fa_c1[0], fa_c1[1], fa_c2[0], fa_c2[1],
                         fa_mid[0], fa_mid[1], hd_ps, hd_pm};
   assign second_half = {fa_mid[0], fa_mid[1], sb_c1[0], sb_c1[1], sb_c2[0], sb_c2[1],
                         hd_p2[0], hd_p2[1], hd_pm, hd_pe};

   bss_emit #(.COORD_WIDTH(COORD_WIDTH), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_emit (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (vld_ff[PIPE_STAGES-1]),
      .first_half  (first_half),
      .second_half (second_half),
      .take        (emit_take),
      .rsp_if      (rsp_if)
   );

endmodule

FILE: design/bss_lerp.sv
// Three-stage saturating fixed-point linear interpolator: subtract, multiply, add and clamp.
module bss_lerp import bss_pkg::*; #(
   parameter int VAL_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  lerp_ctrl_type               ctrl,
   input  logic signed [VAL_WIDTH-1:0] a,
   input  logic signed [VAL_WIDTH-1:0] b,
   input  logic [FRAC_BITS:0]          t,
   output logic signed [VAL_WIDTH-1:0] y
);

   localparam int DIFF_WIDTH = VAL_WIDTH + 1;
   localparam int PROD_WIDTH = DIFF_WIDTH + FRAC_BITS + 2;
   localparam int SUM_WIDTH  = VAL_WIDTH + 4;
   localparam int TOP_WIDTH  = SUM_WIDTH - VAL_WIDTH + 1;

   logic signed [DIFF_WIDTH-1:0] diff_ff, diff_in;
   logic signed [VAL_WIDTH-1:0]  a1_ff;
   logic [FRAC_BITS:0]           t1_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic signed [VAL_WIDTH-1:0]  a2_ff;
   logic signed [VAL_WIDTH-1:0]  y_ff, y_in;
   logic signed [SUM_WIDTH-1:0]  sum;
   logic [TOP_WIDTH-1:0]         sum_top;

   assign diff_in = DIFF_WIDTH'(b) - DIFF_WIDTH'(a);
   assign prod_in = PROD_WIDTH'(diff_ff) * PROD_WIDTH'($signed({1'b0, t1_ff}));
   assign sum     = SUM_WIDTH'(a2_ff) + SUM_WIDTH'(prod_ff >>> FRAC_BITS);
   assign sum_top = sum[SUM_WIDTH-1:VAL_WIDTH-1];

   always_comb begin
      if ((&sum_top) || !(|sum_top)) begin
         y_in = sum[VAL_WIDTH-1:0];
      end else if (sum[SUM_WIDTH-1]) begin
         y_in = {1'b1, {(VAL_WIDTH-1){1'b0}}};
      end else begin
         y_in = {1'b0, {(VAL_WIDTH-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_en) begin
         diff_ff <= diff_in;
         a1_ff   <= a;
         t1_ff   <= t;
      end
      if (ctrl.s2_en) begin
         prod_ff <= prod_in;
         a2_ff   <= a1_ff;
      end
      if (ctrl.s3_en) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

FILE: design/bss_delay.sv
// Shift line with a per-stage advance enable, aligning side data with the lerp stages.
module bss_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 3
) (
   input  logic             clock,
   input  logic [DEPTH-1:0] en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         tap_ff[0] <= din;
      end
      for (int i = 1; i < DEPTH; i++) begin
         if (en[i]) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

FILE: design/bss_emit.sv
// Output register that sends the first half and then the second half as two transactions.
module bss_emit #(
   parameter int COORD_WIDTH     = 32,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   input  logic [8*COORD_WIDTH+2*(PARAM_FRAC_BITS+1)-1:0]  first_half,
   input  logic [8*COORD_WIDTH+2*(PARAM_FRAC_BITS+1)-1:0]  second_half,
   output logic                                            take,
   bss_rsp_if.source                                       rsp_if
);

   localparam int PW         = PARAM_FRAC_BITS + 1;
   localparam int HALF_WIDTH = 8 * COORD_WIDTH + 2 * PW;
   localparam int PT_BASE    = 2 * PW;

   logic                  vld_ff, vld_in;
   logic                  beat_ff, beat_in;
   logic [HALF_WIDTH-1:0] cur_ff, cur_in;
   logic [HALF_WIDTH-1:0] nxt_ff, nxt_in;

   assign take = !vld_ff || (rsp_if.ready && beat_ff);

   always_comb begin
      vld_in  = vld_ff;
      beat_in = beat_ff;
      cur_in  = cur_ff;
      nxt_in  = nxt_ff;
      if (take) begin
         vld_in  = in_valid;
         beat_in = 1'b0;
         cur_in  = first_half;
         nxt_in  = second_half;
      end else if (rsp_if.ready) begin
         beat_in = 1'b1;
         cur_in  = nxt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         beat_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      nxt_ff <= nxt_in;
   end

   assign rsp_if.valid            = vld_ff;
   assign rsp_if.is_last          = beat_ff;
   assign rsp_if.half_p1_x        = cur_ff[PT_BASE+8*COORD_WIDTH-1 -: COORD_WIDTH];
   assign rsp_if.half_p1_y        = cur_ff[PT_BASE+7*COORD_WIDTH-1 -: COORD_WIDTH];
   assign rsp_if.half_c1_x        = cur_ff[PT_BASE+6*COORD_WIDTH-1 -: COORD_WIDTH];
   assign rsp_if.half_c1_y        = cur_ff[PT_BASE+5*COORD_WIDTH-1 -: COORD_WIDTH];
   assign rsp_if.half_c2_x        = cur_ff[PT_BASE+4*COORD_WIDTH-1 -: COORD_WIDTH];
   assign rsp_if.half_c2_y        = cur_ff[PT_BASE+3*COORD_WIDTH-1 -: COORD_WIDTH];
   assign rsp_if.half_p2_x        = cur_ff[PT_BASE+2*COORD_WIDTH-1 -: COORD_WIDTH];
   assign rsp_if.half_p2_y        = cur_ff[PT_BASE+COORD_WIDTH-1 -: COORD_WIDTH];
   assign rsp_if.half_param_start = cur_ff[2*PW-1 -: PW];
   assign rsp_if.half_param_end   = cur_ff[PW-1:0];

endmodule
